// ===== hdl/prg_pkg.sv =====
// ----------------------------------------------------------------------------
// Primary ray generator package
// Shared types, register map, reset values and pipeline depths.
// ----------------------------------------------------------------------------
package prg_pkg;

   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = 3;
   localparam int SQRT_STEPS = 31;   // one root bit per stage
   localparam int DIV_STEPS  = 31;   // one quotient bit per stage
   localparam int DIV_LAT    = DIV_STEPS + 1;

   localparam logic [REG_IDX_W-1:0] REG_ROW0_A    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW0_B    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_A    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_B    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_A    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_B    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_VIEW      = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_PIX_FOCUS = 3'd7;

   localparam logic [63:0] REG_RESET [NUM_REGS] = '{
      64'd281474976710656, 64'd0, 64'd65536, 64'd0,
      64'd0, 64'd281474976710656, 64'd281479271743488, 64'd1099511693312
   };

   typedef struct packed {
      logic                    valid;
      logic                    zero;
      logic [2:0]              neg;
      logic [2:0][31:0]        origin;
   } side_type;

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/primary_ray_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Primary ray generator
// Pinhole camera: pixel centre and lens point through an affine inverse
// matrix, giving a saturated Q16.16 origin and a Q2.30 unit direction.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  request   start / busy         req_pixel_col, req_pixel_row, req_lens_offset_*
//  response  rsp_valid (strobe)   rsp_origin_*, rsp_dir_*, rsp_zero_length
//  config    csr_write_en         csr_index, csr_data
//
//  One transfer is taken every cycle (busy stays low), and its response strobe
//  is registered at the output. The depth is set by the root (one bit a stage,
//  31 stages) and the three dividers (a dividend stage, then one quotient bit
//  a stage, 32 stages in all), behind ten stages of transform and normalise
//  and ahead of the output register.
//  Reset clears the valid bits and restores the register defaults.
//  The receiver cannot stall, so the pipe simply advances every cycle.
//
module primary_ray_generator_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [11:0]        req_pixel_col,
   input  logic [11:0]        req_pixel_row,
   input  logic signed [31:0] req_lens_offset_x,
   input  logic signed [31:0] req_lens_offset_y,
   input  logic               csr_write_en,
   input  logic [prg_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [63:0]        csr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_origin_x,
   output logic signed [31:0] rsp_origin_y,
   output logic signed [31:0] rsp_origin_z,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic signed [31:0] rsp_dir_z,
   output logic               rsp_zero_length
);
   import prg_pkg::*;

   localparam logic [11:0] COL_MASK = 12'((17'd1 << COORD_BITS) - 17'd1);

   // ---------------- configuration registers ----------------
   logic [63:0] regs_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= REG_RESET[i];
         end
      end else if (csr_write_en) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   logic signed [31:0] mat [3][4];
   logic signed [31:0] half_w, half_h, pix_size, focus;

   always_comb begin
      mat[0][0] = regs_ff[REG_ROW0_A][63:32];
      mat[0][1] = regs_ff[REG_ROW0_A][31:0];
      mat[0][2] = regs_ff[REG_ROW0_B][63:32];
      mat[0][3] = regs_ff[REG_ROW0_B][31:0];
      mat[1][0] = regs_ff[REG_ROW1_A][63:32];
      mat[1][1] = regs_ff[REG_ROW1_A][31:0];
      mat[1][2] = regs_ff[REG_ROW1_B][63:32];
      mat[1][3] = regs_ff[REG_ROW1_B][31:0];
      mat[2][0] = regs_ff[REG_ROW2_A][63:32];
      mat[2][1] = regs_ff[REG_ROW2_A][31:0];
      mat[2][2] = regs_ff[REG_ROW2_B][63:32];
      mat[2][3] = regs_ff[REG_ROW2_B][31:0];
      half_w    = regs_ff[REG_VIEW][63:32];
      half_h    = regs_ff[REG_VIEW][31:0];
      pix_size  = regs_ff[REG_PIX_FOCUS][63:32];
      focus     = regs_ff[REG_PIX_FOCUS][31:0];
   end

   // the pipe never stalls: take a transfer whenever start is high
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------- stage 1: (2c+1) * pixel size ----------------
   logic                v1_ff;
   logic signed [45:0]  prodx_ff, prody_ff;
   logic signed [31:0]  lx1_ff, ly1_ff;
   logic [11:0]         col, row;

   always_comb begin
      col = req_pixel_col & COL_MASK;
      row = req_pixel_row & COL_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      prodx_ff <= 46'(signed'({1'b0, col, 1'b1})) * 46'(pix_size);
      prody_ff <= 46'(signed'({1'b0, row, 1'b1})) * 46'(pix_size);
      lx1_ff   <= req_lens_offset_x;
      ly1_ff   <= req_lens_offset_y;
   end

   // ---------------- stage 2: image-plane point ----------------
   logic                v2_ff;
   logic signed [31:0]  wx_ff, wy_ff, nf_ff, lx2_ff, ly2_ff;
   logic signed [47:0]  tx, ty;

   always_comb begin
      tx = (48'(half_w) <<< 1) - 48'(prodx_ff) + 48'sd1;
      ty = (48'(half_h) <<< 1) - 48'(prody_ff) + 48'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff  <= sat32(66'(tx >>> 1));
      wy_ff  <= sat32(66'(ty >>> 1));
      nf_ff  <= sat32(-66'(focus));
      lx2_ff <= lx1_ff;
      ly2_ff <= ly1_ff;
   end

   // ---------------- stage 3: matrix products ----------------
   logic               v3_ff;
   logic signed [63:0] po_ff [3][2];
   logic signed [63:0] pp_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         po_ff[r][0] <= 64'(mat[r][0]) * 64'(lx2_ff);
         po_ff[r][1] <= 64'(mat[r][1]) * 64'(ly2_ff);
         pp_ff[r][0] <= 64'(mat[r][0]) * 64'(wx_ff);
         pp_ff[r][1] <= 64'(mat[r][1]) * 64'(wy_ff);
         pp_ff[r][2] <= 64'(mat[r][2]) * 64'(nf_ff);
      end
   end

   // ---------------- stage 4: sum, round half up, translate ----------------
   logic               v4_ff;
   logic signed [31:0] org_ff [3];
   logic signed [31:0] pix_ff [3];
   logic signed [65:0] so [3];
   logic signed [65:0] sp [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         so[r] = 66'(po_ff[r][0]) + 66'(po_ff[r][1]) + 66'sd32768;
         sp[r] = 66'(pp_ff[r][0]) + 66'(pp_ff[r][1]) + 66'(pp_ff[r][2]) + 66'sd32768;
         so[r] = (so[r] >>> 16) + 66'(mat[r][3]);
         sp[r] = (sp[r] >>> 16) + 66'(mat[r][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         org_ff[r] <= sat32(so[r]);
         pix_ff[r] <= sat32(sp[r]);
      end
   end

   // ---------------- stage 5: difference and magnitude ----------------
   side_type           s5_ff;
   logic [32:0]        a5_ff [3];
   logic signed [32:0] d5 [3];
   side_type           s5_in;

   always_comb begin
      s5_in.valid = v4_ff;
      for (int r = 0; r < 3; r++) begin
         d5[r]           = 33'(pix_ff[r]) - 33'(org_ff[r]);
         s5_in.neg[r]    = d5[r][32];
         s5_in.origin[r] = org_ff[r];
      end
      s5_in.zero = (d5[0] == '0) && (d5[1] == '0) && (d5[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff <= '0;
      end else begin
         s5_ff <= s5_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         a5_ff[r] <= d5[r][32] ? 33'(-d5[r]) : 33'(d5[r]);
      end
   end

   // ---------------- stage 6: largest magnitude ----------------
   side_type    s6_ff;
   logic [32:0] a6_ff [3];
   logic [32:0] mx6_ff;
   logic [32:0] mx01;

   always_comb begin
      mx01 = (a5_ff[1] > a5_ff[0]) ? a5_ff[1] : a5_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ff <= '0;
      end else begin
         s6_ff <= s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      a6_ff  <= a5_ff;
      mx6_ff <= (a5_ff[2] > mx01) ? a5_ff[2] : mx01;
   end

   // ---------------- stage 7: leading one position ----------------
   side_type    s7_ff;
   logic [32:0] a7_ff [3];
   logic [5:0]  pos7_ff;
   logic [5:0]  pos;

   always_comb begin
      pos = '0;
      for (int b = 0; b < 33; b++) begin
         if (mx6_ff[b]) begin
            pos = 6'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff <= '0;
      end else begin
         s7_ff <= s6_ff;
      end
   end

   always_ff @(posedge clock) begin
      a7_ff   <= a6_ff;
      pos7_ff <= pos;
   end

   // ---------------- stage 8: normalise so the largest sits at bit 29 ----------------
   side_type    s8_ff;
   logic [29:0] a8_ff [3];
   logic [29:0] an [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (pos7_ff > 6'd29) begin
            an[r] = 30'(a7_ff[r] >> (pos7_ff - 6'd29));
         end else begin
            an[r] = 30'(a7_ff[r] << (6'd29 - pos7_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff <= '0;
      end else begin
         s8_ff <= s7_ff;
      end
   end

   always_ff @(posedge clock) begin
      a8_ff <= an;
   end

   // ---------------- stage 9: squares ----------------
   side_type    s9_ff;
   logic [29:0] a9_ff [3];
   logic [59:0] sq9_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ff <= '0;
      end else begin
         s9_ff <= s8_ff;
      end
   end

   always_ff @(posedge clock) begin
      a9_ff <= a8_ff;
      for (int r = 0; r < 3; r++) begin
         sq9_ff[r] <= 60'(a8_ff[r]) * 60'(a8_ff[r]);
      end
   end

   // ---------------- stage 10: sum of squares ----------------
   side_type                  s10_ff;
   logic [29:0]               a10_ff [3];
   logic [2*SQRT_STEPS-1:0]   ssum10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_ff <= '0;
      end else begin
         s10_ff <= s9_ff;
      end
   end

   always_ff @(posedge clock) begin
      a10_ff    <= a9_ff;
      ssum10_ff <= (2*SQRT_STEPS)'(sq9_ff[0]) + (2*SQRT_STEPS)'(sq9_ff[1])
                 + (2*SQRT_STEPS)'(sq9_ff[2]);
   end

   // ---------------- length: pipelined root ----------------
   logic [SQRT_STEPS-1:0] len;
   side_type              side_sq_ff [SQRT_STEPS];
   logic [29:0]           a_sq_ff    [SQRT_STEPS][3];

   prg_sqrt u_sqrt (
      .clock    (clock),
      .radicand (ssum10_ff),
      .root     (len)
   );

   // hold the side information level with the root stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            side_sq_ff[k] <= '0;
         end
      end else begin
         side_sq_ff[0] <= s10_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            side_sq_ff[k] <= side_sq_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_sq_ff[0] <= a10_ff;
      for (int k = 1; k < SQRT_STEPS; k++) begin
         a_sq_ff[k] <= a_sq_ff[k-1];
      end
   end

   // ---------------- unit direction: three dividers ----------------
   logic [DIV_STEPS-1:0] quo [3];
   side_type             side_dv_ff [DIV_LAT];

   for (genvar r = 0; r < 3; r++) begin : g_div
      prg_div u_div (
         .clock     (clock),
         .magnitude (a_sq_ff[SQRT_STEPS-1][r]),
         .divisor   (DIV_STEPS'(len)),
         .quotient  (quo[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            side_dv_ff[k] <= '0;
         end
      end else begin
         side_dv_ff[0] <= side_sq_ff[SQRT_STEPS-1];
         for (int k = 1; k < DIV_LAT; k++) begin
            side_dv_ff[k] <= side_dv_ff[k-1];
         end
      end
   end

   // ---------------- output register ----------------
   side_type           fin;
   logic signed [31:0] dir [3];

   always_comb begin
      fin = side_dv_ff[DIV_LAT-1];
      for (int r = 0; r < 3; r++) begin
         if (fin.zero) begin
            dir[r] = '0;                       // drop the direction on a zero-length ray
         end else if (fin.neg[r]) begin
            dir[r] = -32'(quo[r]);
         end else begin
            dir[r] = 32'(quo[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_origin_x    <= fin.origin[0];
      rsp_origin_y    <= fin.origin[1];
      rsp_origin_z    <= fin.origin[2];
      rsp_dir_x       <= dir[0];
      rsp_dir_y       <= dir[1];
      rsp_dir_z       <= dir[2];
      rsp_zero_length <= fin.zero;
   end

endmodule

// ===== hdl/prg_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module prg_sqrt (
   input  logic                          clock,
   input  logic [2*prg_pkg::SQRT_STEPS-1:0] radicand,
   output logic [prg_pkg::SQRT_STEPS-1:0]   root
);
   import prg_pkg::*;

   localparam int RW = 2 * SQRT_STEPS;

   logic [RW-1:0]           rad_ff  [SQRT_STEPS];
   logic [SQRT_STEPS+2:0]   rem_ff  [SQRT_STEPS];
   logic [SQRT_STEPS-1:0]   root_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam int I = SQRT_STEPS - 1 - k;
      logic [RW-1:0]           rad_prev;
      logic [SQRT_STEPS+2:0]   rem_prev;
      logic [SQRT_STEPS-1:0]   root_prev;
      logic [SQRT_STEPS+4:0]   shifted;
      logic [SQRT_STEPS+4:0]   trial;
      logic                    ge;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev, rad_prev[2*I+1 -: 2]};
         trial   = {3'b000, root_prev, 2'b01};
         ge      = (shifted >= trial);
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_prev;
         rem_ff[k]  <= ge ? (SQRT_STEPS+3)'(shifted - trial) : (SQRT_STEPS+3)'(shifted);
         root_ff[k] <= {root_prev[SQRT_STEPS-2:0], ge};
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

// ===== hdl/prg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Forms (a * 2^30 + len / 2) and divides by len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prg_div (
   input  logic                         clock,
   input  logic [29:0]                  magnitude,
   input  logic [prg_pkg::DIV_STEPS-1:0] divisor,
   output logic [prg_pkg::DIV_STEPS-1:0] quotient
);
   import prg_pkg::*;

   localparam int NW = 30 + DIV_STEPS;

   logic [NW-1:0]        num0_ff;
   logic [DIV_STEPS-1:0] dvs0_ff;
   logic [NW-1:0]        num_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dvs_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];

   // build the rounded dividend
   always_ff @(posedge clock) begin
      num0_ff <= NW'({magnitude, 30'b0}) + NW'(divisor >> 1);
      dvs0_ff <= divisor;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int I = DIV_STEPS - 1 - k;
      logic [NW-1:0]        num_prev;
      logic [DIV_STEPS-1:0] dvs_prev;
      logic [DIV_STEPS-1:0] rem_prev;
      logic [DIV_STEPS-1:0] quo_prev;
      logic [DIV_STEPS:0]   t;
      logic                 ge;

      if (k == 0) begin : g_first
         assign num_prev = num0_ff;
         assign dvs_prev = dvs0_ff;
         assign rem_prev = DIV_STEPS'(num0_ff[NW-1:DIV_STEPS]);
         assign quo_prev = '0;
      end else begin : g_next
         assign num_prev = num_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         t  = {rem_prev, num_prev[I]};
         ge = (t >= {1'b0, dvs_prev});
      end

      always_ff @(posedge clock) begin
         num_ff[k] <= num_prev;
         dvs_ff[k] <= dvs_prev;
         rem_ff[k] <= ge ? DIV_STEPS'(t - {1'b0, dvs_prev}) : DIV_STEPS'(t);
         quo_ff[k] <= {quo_prev[DIV_STEPS-2:0], ge};
      end
   end

   assign quotient = quo_ff[DIV_STEPS-1];

endmodule
